[hdl/assert_macros.svh]
// Assertion macros used by the rational adder RTL.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RAN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAN_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RAN_ASSERT(lbl, prop, msg)
`define RAN_NEVER(lbl, expr, msg)
`endif
`endif

[hdl/ran_pkg.sv]
// Package for the rational adder: widths, state type and the structs
// passed between the GCD unit, the divider cells and the top level.
`timescale 1ns / 1ps
package ran_pkg;
  localparam int WORD_W     = 32;
  localparam int REM_W      = WORD_W - 1;
  localparam int DIV_STAGES = WORD_W;
  localparam int CNT_W      = $clog2(DIV_STAGES + 1);
  localparam int SHIFT_W    = $clog2(WORD_W);
  localparam int NUM_W      = 16;
  localparam int DEN_W      = 15;
  localparam int SDEN_W     = 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_GCD,
    ST_DIV
  } ran_state_t;

  // One stage of the restoring divider: two dividends share one divisor.
  typedef struct packed {
    logic [REM_W-1:0]  rem_a;
    logic [WORD_W-1:0] word_a;
    logic [REM_W-1:0]  rem_b;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] divisor;
  } ran_cell_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] g;
  } ran_gcd_res_t;
endpackage

[hdl/ran_if.sv]
// Valid/ready channel interfaces for operand and result items.
// Depends on ran_pkg.
`timescale 1ns / 1ps
interface ran_in_if;
  import ran_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] a_num;
  logic [DEN_W-1:0]        a_den;
  logic signed [NUM_W-1:0] b_num;
  logic [DEN_W-1:0]        b_den;
  modport source (output valid, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, a_num, a_den, b_num, b_den, output ready);
endinterface

interface ran_out_if;
  import ran_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] sum_num;
  logic [SDEN_W-1:0]        sum_den;
  logic                     a_greater;
  logic                     a_equal;
  modport source (output valid, sum_num, sum_den, a_greater, a_equal, input ready);
  modport sink (input valid, sum_num, sum_den, a_greater, a_equal, output ready);
endinterface

[hdl/rational_add_normalize.sv]
// Adds two rationals a_num/a_den + b_num/b_den and returns the sum in
// lowest terms with the sign on the numerator (a zero sum gives 0/1), plus
// a_greater (a > b by cross products) and a_equal (fields identical). One
// item is worked at a time: the cross products are registered in the
// multiply state, the sum is formed in the load state, which starts a
// binary GCD loop of one step per cycle, and in the divide state the row
// of 32 divider cells divides numerator and denominator by the GCD; the
// block then returns to idle to take the next item. The divide state is
// held while an earlier result still waits on a stalled output. A new item
// may be accepted while the previous result still waits on the output.
// Depends on ran_pkg, ran_if, ran_gcd, ran_div_chain, assert_macros.svh.
`timescale 1ns / 1ps
module rational_add_normalize (
  input logic       clk,
  input logic       rst_n,
  ran_in_if.sink    in_ch,
  ran_out_if.source out_ch
);
  import ran_pkg::*;
  `include "assert_macros.svh"

  ran_state_t state_r, state_nxt;
  logic [CNT_W-1:0] div_cnt_r;

  logic signed [NUM_W-1:0]  a_num_r, b_num_r;
  logic [DEN_W-1:0]         a_den_r, b_den_r;
  logic signed [WORD_W-1:0] lt_r, rt_r;
  logic [SDEN_W-1:0]        d_r;
  logic [WORD_W-1:0]        mag_r, mag_nxt;
  logic                     neg_r, neg_nxt, greater_r, greater_nxt, equal_r;
  logic signed [WORD_W:0]   n_sum, n_dif;

  logic in_take, gcd_start, div_end, load_out;
  ran_gcd_res_t gcd_res;
  ran_cell_t    head, tail;

  logic                     out_valid_r;
  logic signed [WORD_W-1:0] sum_num_r;
  logic [SDEN_W-1:0]        sum_den_r;
  logic                     a_greater_r, a_equal_r;
  logic [WORD_W-1:0]        q_num;

  assign in_take = in_ch.valid && in_ch.ready;
  assign div_end = (state_r == ST_DIV) && (div_cnt_r == CNT_W'(DIV_STAGES));

  always_comb begin
    n_sum       = {lt_r[WORD_W-1], lt_r} + {rt_r[WORD_W-1], rt_r};
    n_dif       = {lt_r[WORD_W-1], lt_r} - {rt_r[WORD_W-1], rt_r};
    neg_nxt     = n_sum[WORD_W];
    mag_nxt     = neg_nxt ? WORD_W'(-n_sum) : n_sum[WORD_W-1:0];
    greater_nxt = !n_dif[WORD_W] && (n_dif != '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_GCD;
      ST_GCD:  if (gcd_res.done) state_nxt = ST_DIV;
      ST_DIV:  if (div_end && (!out_valid_r || out_ch.ready)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    gcd_start   = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_LOAD: gcd_start = 1'b1;
      ST_DIV:  load_out = div_end && (!out_valid_r || out_ch.ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r != ST_DIV) begin
        div_cnt_r <= '0;
      end else if (!div_end) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_num_r <= in_ch.a_num;
      a_den_r <= in_ch.a_den;
      b_num_r <= in_ch.b_num;
      b_den_r <= in_ch.b_den;
      equal_r <= (in_ch.a_num == in_ch.b_num) && (in_ch.a_den == in_ch.b_den);
    end
    if (state_r == ST_MUL) begin
      lt_r <= a_num_r * $signed({1'b0, b_den_r});
      rt_r <= b_num_r * $signed({1'b0, a_den_r});
      d_r  <= a_den_r * b_den_r;
    end
    if (state_r == ST_LOAD) begin
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      greater_r <= greater_nxt;
    end
  end

  ran_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .x0    (mag_nxt),
    .y0    (WORD_W'(d_r)),
    .res   (gcd_res)
  );

  // The head stays constant through the divide, so the tail settles and holds.
  always_comb begin
    head.rem_a   = '0;
    head.word_a  = mag_r;
    head.rem_b   = '0;
    head.word_b  = WORD_W'(d_r);
    head.divisor = gcd_res.g;
  end

  ran_div_chain u_div (
    .clk  (clk),
    .head (head),
    .tail (tail)
  );

  // A zero GCD only arises for 0/0, which passes through unreduced.
  assign q_num = (gcd_res.g == '0) ? mag_r : tail.word_a;

  always_ff @(posedge clk) begin
    if (load_out) begin
      sum_num_r   <= neg_r ? -$signed(q_num) : $signed(q_num);
      sum_den_r   <= (gcd_res.g == '0) ? d_r : tail.word_b[SDEN_W-1:0];
      a_greater_r <= greater_r;
      a_equal_r   <= equal_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.sum_num   = sum_num_r;
  assign out_ch.sum_den   = sum_den_r;
  assign out_ch.a_greater = a_greater_r;
  assign out_ch.a_equal   = a_equal_r;

  `RAN_ASSERT(a_gcd_done_in_gcd, gcd_res.done |-> (state_r == ST_GCD), "GCD done outside GCD state")
  `RAN_ASSERT(a_gcd_running, (state_r == ST_GCD) |-> (gcd_res.busy || gcd_res.done), "GCD idle in GCD state")
  `RAN_ASSERT(a_load_after_chain, load_out |-> (div_cnt_r == CNT_W'(DIV_STAGES)), "result taken before divider settled")
  `RAN_NEVER(a_no_take_busy, in_take && (state_r != ST_IDLE), "item accepted while busy")
endmodule

[hdl/ran_gcd.sv]
// Binary (Stein) GCD unit, one subtract-or-halve step per cycle.
// Depends on ran_pkg.
`timescale 1ns / 1ps
module ran_gcd (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ran_pkg::WORD_W-1:0] x0,
  input  logic [ran_pkg::WORD_W-1:0] y0,
  output ran_pkg::ran_gcd_res_t      res
);
  import ran_pkg::*;

  logic [WORD_W-1:0]  x_r, x_nxt, y_r, y_nxt, g_r;
  logic [SHIFT_W-1:0] k_r, k_nxt;
  logic               busy_r, done_r, fin;

  assign fin = (x_r == '0) || (y_r == '0);

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    if (!x_r[0] && !y_r[0]) begin
      x_nxt = x_r >> 1;
      y_nxt = y_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!x_r[0]) begin
      x_nxt = x_r >> 1;
    end else if (!y_r[0]) begin
      y_nxt = y_r >> 1;
    end else if (x_r >= y_r) begin
      // Both odd: the difference is even, so halve it at once.
      x_nxt = (x_r - y_r) >> 1;
    end else begin
      y_nxt = (y_r - x_r) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && fin;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && fin) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x0;
      y_r <= y0;
      k_r <= '0;
    end else if (busy_r && fin) begin
      // One operand is zero, so the OR is the other one.
      g_r <= (x_r | y_r) << k_r;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      k_r <= k_nxt;
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.g    = g_r;
endmodule

[hdl/ran_cell.sv]
// One restoring-division cell: one quotient bit for each of two dividends.
// Depends on ran_pkg.
`timescale 1ns / 1ps
module ran_cell (
  input  logic               clk,
  input  ran_pkg::ran_cell_t prev,
  output ran_pkg::ran_cell_t next
);
  import ran_pkg::*;

  ran_cell_t         next_r, next_nxt;
  logic [WORD_W-1:0] sh_a, sh_b, dif_a, dif_b;
  logic              ge_a, ge_b;

  always_comb begin
    sh_a  = {prev.rem_a, prev.word_a[WORD_W-1]};
    sh_b  = {prev.rem_b, prev.word_b[WORD_W-1]};
    ge_a  = sh_a >= prev.divisor;
    ge_b  = sh_b >= prev.divisor;
    dif_a = sh_a - prev.divisor;
    dif_b = sh_b - prev.divisor;
    next_nxt.rem_a   = ge_a ? dif_a[REM_W-1:0] : sh_a[REM_W-1:0];
    next_nxt.rem_b   = ge_b ? dif_b[REM_W-1:0] : sh_b[REM_W-1:0];
    // Dividend bits leave at the top while quotient bits enter at the bottom.
    next_nxt.word_a  = {prev.word_a[WORD_W-2:0], ge_a};
    next_nxt.word_b  = {prev.word_b[WORD_W-2:0], ge_b};
    next_nxt.divisor = prev.divisor;
  end

  always_ff @(posedge clk) begin
    next_r <= next_nxt;
  end

  assign next = next_r;
endmodule

[hdl/ran_div_chain.sv]
// Row of registered divider cells; the tail holds both quotients once the
// stable head has passed through every cell. Depends on ran_pkg, ran_cell.
`timescale 1ns / 1ps
module ran_div_chain (
  input  logic               clk,
  input  ran_pkg::ran_cell_t head,
  output ran_pkg::ran_cell_t tail
);
  import ran_pkg::*;

  ran_cell_t link [DIV_STAGES+1];

  assign link[0] = head;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_cell
    ran_cell u_cell (
      .clk  (clk),
      .prev (link[i]),
      .next (link[i+1])
    );
  end

  assign tail = link[DIV_STAGES];
endmodule
